// ===== rtl/strs_pkg.sv =====
// Shared constants and types for the segment tree range sum unit.
// No dependencies; every other file in rtl/ imports this package.
package strs_pkg;

	localparam int unsigned LEAVES = 1024;
	localparam int unsigned POS_W  = 10;
	localparam int unsigned DATA_W = 32;
	localparam int unsigned NODES  = 2 * LEAVES;
	localparam int unsigned ADDR_W = $clog2(NODES);
	localparam int unsigned IDX_W  = $clog2(NODES + 1);
	localparam int unsigned CMP_W  = (IDX_W > POS_W) ? IDX_W : POS_W;

	localparam logic MODE_ADD   = 1'b0;
	localparam logic MODE_QUERY = 1'b1;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_ADD_LEAF,
		ST_ADD_SIB,
		ST_ADD_UP,
		ST_Q_RD,
		ST_Q_ACC,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic              we;
		logic [ADDR_W-1:0] waddr;
		logic [DATA_W-1:0] wdata;
		logic [ADDR_W-1:0] raddr_a;
		logic [ADDR_W-1:0] raddr_b;
	} mem_req_t;

	typedef struct packed {
		logic              valid;
		logic [DATA_W-1:0] sum;
	} result_t;

endpackage

// ===== rtl/strs_ram.sv =====
// Tree node store: one write port, two read ports, registered read data.
// Depends on strs_pkg for depth, widths and the request struct.
module strs_ram
	import strs_pkg::*;
(
	input  logic              clk,
	input  mem_req_t          req,
	output logic [DATA_W-1:0] rdata_a,
	output logic [DATA_W-1:0] rdata_b
);

	logic [DATA_W-1:0] mem [NODES];
	logic [DATA_W-1:0] rdata_a_q;
	logic [DATA_W-1:0] rdata_b_q;

	always_ff @(posedge clk) begin
		if (req.we) begin
			mem[req.waddr] <= req.wdata;
		end
		rdata_a_q <= mem[req.raddr_a];
		rdata_b_q <= mem[req.raddr_b];
	end

	assign rdata_a = rdata_a_q;
	assign rdata_b = rdata_b_q;

endmodule

// ===== rtl/strs_ctrl.sv =====
// Sequencer and datapath: clearing pass, leaf add with ancestor rebuild,
// two-pointer range query. Depends on strs_pkg; drives strs_ram.
module strs_ctrl
	import strs_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic                     mode,
	input  logic [POS_W-1:0]         position,
	input  logic [POS_W-1:0]         upper,
	input  logic signed [DATA_W-1:0] amount,
	output mem_req_t                 mem_req,
	input  logic [DATA_W-1:0]        rdata_a,
	input  logic [DATA_W-1:0]        rdata_b,
	output result_t                  res,
	input  logic                     res_ready
);

	state_t            state_q, state_d;
	logic [ADDR_W-1:0] clr_q;
	logic [ADDR_W-1:0] x_q;
	logic [DATA_W-1:0] amt_q;
	logic [DATA_W-1:0] cur_q;
	logic [DATA_W-1:0] acc_q;
	logic [IDX_W-1:0]  l_q;
	logic [IDX_W-1:0]  r_q;

	logic [CMP_W-1:0]  pos_c, up_c, leaves_c, hi_c;
	logic              add_ok, empty, accept;
	logic [IDX_W-1:0]  lo_idx, r_init, r_dec, l_next;
	logic [ADDR_W-1:0] parent;
	logic [DATA_W-1:0] leaf_sum, up_sum, acc_sum;

	assign pos_c    = CMP_W'(position);
	assign up_c     = CMP_W'(upper);
	assign leaves_c = CMP_W'(LEAVES);
	assign hi_c     = (up_c >= leaves_c) ? leaves_c - CMP_W'(1) : up_c;
	assign add_ok   = pos_c < leaves_c;
	assign empty    = pos_c > hi_c;
	assign lo_idx   = IDX_W'(pos_c) + IDX_W'(LEAVES);
	assign r_init   = IDX_W'(hi_c) + IDX_W'(LEAVES) + IDX_W'(1);
	assign r_dec    = r_q - IDX_W'(1);
	assign l_next   = IDX_W'((l_q + IDX_W'(l_q[0])) >> 1);
	assign parent   = x_q >> 1;
	assign accept   = in_valid && in_ready;

	assign leaf_sum = rdata_a + amt_q;
	assign up_sum   = cur_q + rdata_a;
	assign acc_sum  = acc_q + (l_q[0] ? rdata_a : '0) + (r_q[0] ? rdata_b : '0);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_CLEAR: begin
				if (clr_q == ADDR_W'(NODES - 1)) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (accept) begin
					if (mode == MODE_ADD) state_d = add_ok ? ST_ADD_LEAF : ST_IDLE;
					else state_d = empty ? ST_DONE : ST_Q_RD;
				end
			end
			ST_ADD_LEAF: state_d = ST_ADD_SIB;
			ST_ADD_SIB:  state_d = ST_ADD_UP;
			ST_ADD_UP: begin
				state_d = (parent != ADDR_W'(1)) ? ST_ADD_SIB : ST_IDLE;
			end
			ST_Q_RD:  state_d = (l_q < r_q) ? ST_Q_ACC : ST_DONE;
			ST_Q_ACC: state_d = ST_Q_RD;
			ST_DONE: begin
				if (res_ready) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready        = (state_q == ST_IDLE);
		mem_req.we      = 1'b0;
		mem_req.waddr   = x_q;
		mem_req.wdata   = leaf_sum;
		mem_req.raddr_a = l_q[ADDR_W-1:0];
		mem_req.raddr_b = r_dec[ADDR_W-1:0];
		res.valid       = (state_q == ST_DONE);
		res.sum         = acc_q;
		unique case (state_q)
			ST_CLEAR: begin
				mem_req.we    = 1'b1;
				mem_req.waddr = clr_q;
				mem_req.wdata = '0;
			end
			ST_IDLE: begin
				mem_req.raddr_a = lo_idx[ADDR_W-1:0];
			end
			ST_ADD_LEAF: begin
				mem_req.we = 1'b1;
			end
			ST_ADD_SIB: begin
				mem_req.raddr_a = x_q ^ ADDR_W'(1);
			end
			ST_ADD_UP: begin
				mem_req.we    = 1'b1;
				mem_req.waddr = parent;
				mem_req.wdata = up_sum;
			end
			ST_Q_RD, ST_Q_ACC, ST_DONE: begin
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			clr_q   <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_CLEAR) clr_q <= clr_q + ADDR_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					x_q   <= lo_idx[ADDR_W-1:0];
					amt_q <= amount;
					l_q   <= lo_idx;
					r_q   <= r_init;
					acc_q <= '0;
				end
			end
			ST_ADD_LEAF: cur_q <= leaf_sum;
			ST_ADD_UP: begin
				cur_q <= up_sum;
				x_q   <= parent;
			end
			ST_Q_ACC: begin
				acc_q <= acc_sum;
				l_q   <= l_next;
				r_q   <= r_q >> 1;
			end
			ST_CLEAR, ST_ADD_SIB, ST_Q_RD, ST_DONE: begin
			end
			default: begin
			end
		endcase
	end

endmodule

// ===== rtl/segment_tree_range_sum_unit.sv =====
// Point-add, range-sum segment tree over LEAVES signed 32-bit positions,
// held in one two-read, one-write node memory and walked one tree level at
// a time. After reset the unit zeroes every node of the memory and takes
// no beat until then. An add beat writes the leaf, then for each level on
// the way to the root reads the sibling and writes the parent. A query
// beat climbs the tree one level per step, up to log2(LEAVES)+1 levels, and
// hands its sum to an output register so the next beat can be taken while
// the result waits. An add beyond the leaves is dropped at once and gives
// no result.
// Depends on strs_pkg, strs_ctrl and strs_ram.
module segment_tree_range_sum_unit
	import strs_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic                     mode,
	input  logic [POS_W-1:0]         position,
	input  logic [POS_W-1:0]         upper,
	input  logic signed [DATA_W-1:0] amount,
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic signed [DATA_W-1:0] range_sum
);

	mem_req_t          mem_req;
	logic [DATA_W-1:0] rdata_a, rdata_b;
	result_t           res;
	logic              res_ready;
	logic              out_valid_q;
	logic [DATA_W-1:0] range_sum_q;

	strs_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.mode      (mode),
		.position  (position),
		.upper     (upper),
		.amount    (amount),
		.mem_req   (mem_req),
		.rdata_a   (rdata_a),
		.rdata_b   (rdata_b),
		.res       (res),
		.res_ready (res_ready)
	);

	strs_ram u_ram (
		.clk     (clk),
		.req     (mem_req),
		.rdata_a (rdata_a),
		.rdata_b (rdata_b)
	);

	assign res_ready = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res.valid && res_ready) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res.valid && res_ready) range_sum_q <= res.sum;
	end

	assign out_valid = out_valid_q;
	assign range_sum = range_sum_q;

endmodule
